FILE: rtl/bilinear_gradient_pixel_core_defines.svh
// Assertion macros used by the checker file.
`ifndef BILINEAR_GRADIENT_PIXEL_CORE_DEFINES_SVH
`define BILINEAR_GRADIENT_PIXEL_CORE_DEFINES_SVH
// Clocked assertion with explicit clock and active-low reset.
`define BGP_ASSERT_CLK(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
// Same, on the checker's clk and rst_n.
`define BGP_ASSERT(lbl, prop, msg) \
  `BGP_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`endif

FILE: rtl/bgp_pkg.sv
// Shared types, widths and constants of the bilinear gradient pixel core.
package bgp_pkg;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int COORD_W = 10;
  localparam int SIZE_W  = 11;
  localparam int COLOR_W = 24;
  localparam int WGT_W   = 2 * SIZE_W;
  localparam int PROD_W  = WGT_W + 8;
  localparam int NUM_W   = 31;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_STAGES = 8;
  // front stages + divider stages + output reg
  localparam int LATENCY = 4 + DIV_STAGES + 1;

  localparam logic [CFG_IDX_W-1:0] REG_TOP_LEFT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_RIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_LEFT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_RIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT       = 3'd5;

  localparam logic [COLOR_W-1:0] RST_TOP_LEFT     = 24'hFF0000;
  localparam logic [COLOR_W-1:0] RST_TOP_RIGHT    = 24'h0000FF;
  localparam logic [COLOR_W-1:0] RST_BOTTOM_LEFT  = 24'hFFFF00;
  localparam logic [COLOR_W-1:0] RST_BOTTOM_RIGHT = 24'h00FF00;
  localparam logic [SIZE_W-1:0]  RST_WIDTH        = 11'd640;
  localparam logic [SIZE_W-1:0]  RST_HEIGHT       = 11'd480;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       out_of_range;
  } out_t;

  typedef struct packed {
    logic [COLOR_W-1:0] top_left;
    logic [COLOR_W-1:0] top_right;
    logic [COLOR_W-1:0] bottom_left;
    logic [COLOR_W-1:0] bottom_right;
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  height;
  } cfg_t;

  // Divider pipeline payload: per-channel remainder and quotient.
  typedef struct packed {
    logic [2:0][NUM_W-1:0] rem;
    logic [2:0][7:0]       quo;
    logic [WGT_W-1:0]      den;
    logic                  oor;
  } div_t;
endpackage

FILE: rtl/bgp_front.sv
// Front pipeline: clamp, weights, weighted colors, numerators.
module bgp_front import bgp_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_vld,
  input  in_t  in_pix,
  input  cfg_t cfg,
  output logic out_vld,
  output div_t out_div
);
  // stage 1: coordinates and edge distances
  logic              s1_vld_r, s1_oor_r;
  logic [SIZE_W-1:0] s1_ax_r, s1_bx_r, s1_ay_r, s1_by_r, s1_w1_r, s1_h1_r;
  logic [COLOR_W-1:0] s1_tl_r, s1_tr_r, s1_bl_r, s1_br_r;
  // stage 2: weights
  logic             s2_vld_r, s2_oor_r;
  logic [WGT_W-1:0] s2_wtl_r, s2_wtr_r, s2_wbl_r, s2_wbr_r, s2_den_r;
  logic [COLOR_W-1:0] s2_tl_r, s2_tr_r, s2_bl_r, s2_br_r;
  // stage 3: weighted channels
  logic              s3_vld_r, s3_oor_r;
  logic [WGT_W-1:0]  s3_den_r;
  logic [2:0][3:0][PROD_W-1:0] s3_prod_r;
  // stage 4 output
  logic s4_vld_r;
  div_t s4_div_r;

  logic [SIZE_W-1:0] w_sat, h_sat, x_ext, y_ext, w1, h1;
  logic [SIZE_W+1:0] mw, mh;

  always_comb begin
    mw    = (SIZE_W+2)'(MAX_WIDTH);
    mh    = (SIZE_W+2)'(MAX_HEIGHT);
    w_sat = ({2'b00, cfg.width}  > mw) ? SIZE_W'(MAX_WIDTH)  : cfg.width;
    h_sat = ({2'b00, cfg.height} > mh) ? SIZE_W'(MAX_HEIGHT) : cfg.height;
    x_ext = {1'b0, in_pix.pixel_x};
    y_ext = {1'b0, in_pix.pixel_y};
    w1    = (w_sat > SIZE_W'(1)) ? w_sat - SIZE_W'(1) : SIZE_W'(1);
    h1    = (h_sat > SIZE_W'(1)) ? h_sat - SIZE_W'(1) : SIZE_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_oor_r <= (x_ext >= w_sat) || (y_ext >= h_sat);
    s1_ax_r  <= x_ext;
    s1_ay_r  <= y_ext;
    s1_bx_r  <= w1 - x_ext;
    s1_by_r  <= h1 - y_ext;
    s1_w1_r  <= w1;
    s1_h1_r  <= h1;
    s1_tl_r  <= cfg.top_left;
    s1_tr_r  <= cfg.top_right;
    s1_bl_r  <= cfg.bottom_left;
    s1_br_r  <= cfg.bottom_right;

    s2_oor_r <= s1_oor_r;
    s2_wtl_r <= s1_bx_r * s1_by_r;
    s2_wtr_r <= s1_ax_r * s1_by_r;
    s2_wbl_r <= s1_bx_r * s1_ay_r;
    s2_wbr_r <= s1_ax_r * s1_ay_r;
    s2_den_r <= s1_w1_r * s1_h1_r;
    s2_tl_r  <= s1_tl_r;
    s2_tr_r  <= s1_tr_r;
    s2_bl_r  <= s1_bl_r;
    s2_br_r  <= s1_br_r;

    s3_oor_r <= s2_oor_r;
    s3_den_r <= s2_den_r;
    for (int c = 0; c < 3; c++) begin
      s3_prod_r[c][0] <= PROD_W'(s2_tl_r[c*8 +: 8]) * PROD_W'(s2_wtl_r);
      s3_prod_r[c][1] <= PROD_W'(s2_tr_r[c*8 +: 8]) * PROD_W'(s2_wtr_r);
      s3_prod_r[c][2] <= PROD_W'(s2_bl_r[c*8 +: 8]) * PROD_W'(s2_wbl_r);
      s3_prod_r[c][3] <= PROD_W'(s2_br_r[c*8 +: 8]) * PROD_W'(s2_wbr_r);
    end

    s4_div_r.oor <= s3_oor_r;
    s4_div_r.den <= s3_den_r;
    s4_div_r.quo <= '0;
    for (int c = 0; c < 3; c++) begin
      // rounding half up: add den/2 before the divide
      s4_div_r.rem[c] <= NUM_W'(s3_prod_r[c][0]) + NUM_W'(s3_prod_r[c][1])
                       + NUM_W'(s3_prod_r[c][2]) + NUM_W'(s3_prod_r[c][3])
                       + NUM_W'(s3_den_r >> 1);
    end
  end

  assign out_vld = s4_vld_r;
  assign out_div = s4_div_r;
endmodule

FILE: rtl/bgp_div_stage.sv
// One restoring-divide stage: settles one quotient bit on all channels.
module bgp_div_stage import bgp_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_vld,
  input  div_t in_div,
  output logic out_vld,
  output div_t out_div
);
  logic vld_r;
  div_t div_r, div_nxt;
  logic [NUM_W-1:0] dsh;

  always_comb begin
    dsh     = NUM_W'(in_div.den) << SHIFT;
    div_nxt = in_div;
    for (int c = 0; c < 3; c++) begin
      if (in_div.rem[c] >= dsh) begin
        div_nxt.rem[c]        = in_div.rem[c] - dsh;
        div_nxt.quo[c][SHIFT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else        vld_r <= in_vld;
    div_r <= div_nxt;
  end

  assign out_vld = vld_r;
  assign out_div = div_r;
endmodule

FILE: rtl/bilinear_gradient_pixel_core.sv
// Top level of the bilinear gradient pixel core.
// Throughput: one pixel per clock while not busy; the 8-stage divider sets the depth.
// Reset (rst_n low, synchronous): pipeline emptied, corner colors and
// screen size back to defaults, busy high until the cycle after reset.
// The receiver cannot stall; each result shows for exactly one cycle.
module bilinear_gradient_pixel_core import bgp_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  in_data,
  output logic                 out_valid,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_wdata
);
  cfg_t cfg_r;
  logic busy_r;
  logic accept;

  // pipeline never stalls, so busy only covers reset
  assign busy   = busy_r;
  assign accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r             <= 1'b1;
      cfg_r.top_left     <= RST_TOP_LEFT;
      cfg_r.top_right    <= RST_TOP_RIGHT;
      cfg_r.bottom_left  <= RST_BOTTOM_LEFT;
      cfg_r.bottom_right <= RST_BOTTOM_RIGHT;
      cfg_r.width        <= RST_WIDTH;
      cfg_r.height       <= RST_HEIGHT;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_TOP_LEFT:     cfg_r.top_left     <= cfg_wdata;
          REG_TOP_RIGHT:    cfg_r.top_right    <= cfg_wdata;
          REG_BOTTOM_LEFT:  cfg_r.bottom_left  <= cfg_wdata;
          REG_BOTTOM_RIGHT: cfg_r.bottom_right <= cfg_wdata;
          REG_WIDTH:        cfg_r.width        <= cfg_wdata[SIZE_W-1:0];
          REG_HEIGHT:       cfg_r.height       <= cfg_wdata[SIZE_W-1:0];
          default: ;  // unknown index: ignored
        endcase
      end
    end
  end

  // front: edge distances, weights, weighted colors, rounded numerators
  logic vld_chain [DIV_STAGES+1];
  div_t div_chain [DIV_STAGES+1];

  bgp_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (accept),
    .in_pix  (in_data),
    .cfg     (cfg_r),
    .out_vld (vld_chain[0]),
    .out_div (div_chain[0])
  );

  // divider: quotient MSB first, one bit per stage
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    bgp_div_stage #(.SHIFT(DIV_STAGES-1-g)) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (vld_chain[g]),
      .in_div  (div_chain[g]),
      .out_vld (vld_chain[g+1]),
      .out_div (div_chain[g+1])
    );
  end

  // output register; off-screen pixels come out black with the flag set
  logic out_valid_r;
  out_t out_data_r, out_nxt;
  div_t fin;

  always_comb begin
    fin = div_chain[DIV_STAGES];
    out_nxt.out_of_range = fin.oor;
    out_nxt.red   = fin.oor ? 8'd0 : fin.quo[2];
    out_nxt.green = fin.oor ? 8'd0 : fin.quo[1];
    out_nxt.blue  = fin.oor ? 8'd0 : fin.quo[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= vld_chain[DIV_STAGES];
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
endmodule

FILE: rtl/bgp_checker.sv
// Port-level checker for the bilinear gradient pixel core, with its bind.
`include "bilinear_gradient_pixel_core_defines.svh"
module bgp_checker import bgp_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input out_t out_data
);
  `BGP_ASSERT(a_out_has_cause, out_valid |-> $past(start && !busy, LATENCY), "result without transfer")
  `BGP_ASSERT(a_in_gives_out, (start && !busy) |-> ##LATENCY out_valid, "transfer without result")
  `BGP_ASSERT(a_oor_black, (out_valid && out_data.out_of_range) |-> (out_data.red == 8'd0 && out_data.green == 8'd0 && out_data.blue == 8'd0), "off-screen pixel not black")
endmodule

bind bilinear_gradient_pixel_core bgp_checker u_bgp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

FILE: verif/tb.sv
// Self-checking testbench for the bilinear gradient pixel core.
module tb;
  import bgp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_t                  in_data;
  logic                 out_valid;
  out_t                 out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COLOR_W-1:0]   cfg_wdata;

  bilinear_gradient_pixel_core u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Shadow of the block's registers, kept by the stimulus process.
  cfg_t shadow_cfg;

  in_t  pixel_queue[$];   // pixels waiting to be driven
  out_t color_queue[$];   // predicted colors, oldest first
  int   sender_idle_pct;
  bit   hold_sender;
  int   mismatches;
  int   pixels_sent;
  int   colors_seen;
  int   configs_run;
  int   oor_seen;
  longint cycle_count;

  // One channel of the gradient, exact integer math, round half up.
  function automatic logic [7:0] blend_channel(int shift, longint x, longint y,
                                               longint w1, longint h1);
    longint tl, tr, bl, br, num, den;
    tl = (shadow_cfg.top_left >> shift) & 8'hFF;
    tr = (shadow_cfg.top_right >> shift) & 8'hFF;
    bl = (shadow_cfg.bottom_left >> shift) & 8'hFF;
    br = (shadow_cfg.bottom_right >> shift) & 8'hFF;
    den = w1 * h1;
    num = tl * (w1 - x) * (h1 - y) + tr * x * (h1 - y)
        + bl * (w1 - x) * y + br * x * y;
    return 8'((num + den / 2) / den);
  endfunction

  function automatic out_t gradient_color(in_t px);
    out_t   c;
    longint w, h, w1, h1;
    w = shadow_cfg.width;
    h = shadow_cfg.height;
    // oversized screens saturate at the maximum
    if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
    if (h > DEF_MAX_HEIGHT) h = DEF_MAX_HEIGHT;
    c = '0;
    if (px.pixel_x >= w || px.pixel_y >= h) begin
      c.out_of_range = 1'b1;
      return c;
    end
    // a one-pixel axis takes its first corner
    w1 = (w > 1) ? w - 1 : 1;
    h1 = (h > 1) ? h - 1 : 1;
    c.red   = blend_channel(16, px.pixel_x, px.pixel_y, w1, h1);
    c.green = blend_channel(8,  px.pixel_x, px.pixel_y, w1, h1);
    c.blue  = blend_channel(0,  px.pixel_x, px.pixel_y, w1, h1);
    return c;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Driver: start rises when a pixel is queued and the sender is not idling.
  // The prediction is taken at the transfer edge, with the live register copy.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        color_queue.push_back(gradient_color(in_data));
        pixels_sent++;
      end
      if (!(start && busy)) begin
        if (pixel_queue.size() > 0 && !hold_sender &&
            $urandom_range(99) >= sender_idle_pct) begin
          start   <= 1'b1;
          in_data <= pixel_queue.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every out_valid strobe is one transfer, checked field by field.
  always @(posedge clk) begin
    out_t exp_c;
    cycle_count++;
    if (rst_n && out_valid) begin
      colors_seen++;
      if (out_data.out_of_range) oor_seen++;
      if (color_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %h with nothing pending", out_data);
      end else begin
        exp_c = color_queue.pop_front();
        if (out_data.red !== exp_c.red || out_data.green !== exp_c.green ||
            out_data.blue !== exp_c.blue ||
            out_data.out_of_range !== exp_c.out_of_range) begin
          mismatches++;
          if (mismatches <= 10)
            $display("color mismatch: expected r%h g%h b%h oor%b, got r%h g%h b%h oor%b",
                     exp_c.red, exp_c.green, exp_c.blue, exp_c.out_of_range,
                     out_data.red, out_data.green, out_data.blue,
                     out_data.out_of_range);
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  // Wait until every queued pixel is sent and every color checked, then let
  // the pipeline drain before touching a register.
  task automatic drain();
    while (pixel_queue.size() > 0 || start || color_queue.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Drives one write for the next edge; set_screen drops cfg_we afterwards.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_TOP_LEFT:     shadow_cfg.top_left     = val;
      REG_TOP_RIGHT:    shadow_cfg.top_right    = val;
      REG_BOTTOM_LEFT:  shadow_cfg.bottom_left  = val;
      REG_BOTTOM_RIGHT: shadow_cfg.bottom_right = val;
      REG_WIDTH:        shadow_cfg.width        = val[SIZE_W-1:0];
      REG_HEIGHT:       shadow_cfg.height       = val[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_screen(logic [COLOR_W-1:0] tl, logic [COLOR_W-1:0] tr,
                            logic [COLOR_W-1:0] bl, logic [COLOR_W-1:0] br,
                            int w, int h);
    write_reg(REG_TOP_LEFT, tl);
    write_reg(REG_TOP_RIGHT, tr);
    write_reg(REG_BOTTOM_LEFT, bl);
    write_reg(REG_BOTTOM_RIGHT, br);
    write_reg(REG_WIDTH, COLOR_W'(w));
    write_reg(REG_HEIGHT, COLOR_W'(h));
    cfg_we <= 1'b0;
    configs_run++;
  endtask

  function automatic void push_pixel(int x, int y);
    in_t p;
    p.pixel_x = COORD_W'(x);
    p.pixel_y = COORD_W'(y);
    pixel_queue.push_back(p);
  endfunction

  // Random pixels: mostly on screen, some at or just past the right edge, some anywhere.
  task automatic random_pixels(int n);
    int w, h, sel;
    w = (shadow_cfg.width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : shadow_cfg.width;
    h = (shadow_cfg.height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : shadow_cfg.height;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(9);
      if (sel < 7 && w > 0 && h > 0)
        push_pixel($urandom_range(w - 1), $urandom_range(h - 1));
      else if (sel < 8)
        push_pixel(w + $urandom_range(1) - 1, $urandom_range(1023));
      else
        push_pixel($urandom_range(1023), $urandom_range(1023));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    hold_sender = 1'b0;
    sender_idle_pct = 32;
    mismatches = 0;
    pixels_sent = 0;
    colors_seen = 0;
    configs_run = 0;
    oor_seen = 0;
    cycle_count = 0;
    shadow_cfg = '{RST_TOP_LEFT, RST_TOP_RIGHT, RST_BOTTOM_LEFT, RST_BOTTOM_RIGHT,
                   RST_WIDTH, RST_HEIGHT};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset colors on a 640x480 screen, corners, edges, off-screen.
    push_pixel(0, 0);     push_pixel(639, 0);
    push_pixel(0, 479);   push_pixel(639, 479);
    push_pixel(320, 240); push_pixel(640, 0);
    push_pixel(0, 480);   push_pixel(1023, 1023);
    push_pixel(682, 341); push_pixel(341, 682);
    // part way through, hold off until the pipeline is empty
    while (pixel_queue.size() > 5)
      @(posedge clk);
    hold_sender = 1'b1;
    while (start || color_queue.size() > 0)
      @(posedge clk);
    hold_sender = 1'b0;
    drain();

    // Saturated 2047x2047 screen clips at 1024; full-scale colors.
    set_screen(24'hFFFFFF, 24'h000000, 24'hAAAAAA, 24'h555555, 2047, 2047);
    push_pixel(1023, 1023); push_pixel(0, 1023); push_pixel(1023, 0);
    push_pixel(0, 0);       push_pixel(512, 512);
    drain();

    // One-pixel axes take the first corner; zero size is all off-screen.
    set_screen(24'h123456, 24'hFEDCBA, 24'h0F0F0F, 24'hF0F0F0, 1, 1);
    push_pixel(0, 0); push_pixel(1, 0); push_pixel(0, 1);
    drain();
    set_screen(24'h123456, 24'hFEDCBA, 24'h0F0F0F, 24'hF0F0F0, 0, 5);
    push_pixel(0, 0); push_pixel(0, 4);
    drain();

    // Random phases, each with its own registers and idling mix.
    for (int ph = 0; ph < 12; ph++) begin
      int w, h;
      sender_idle_pct = (ph < 4) ? 32 : (ph < 8) ? 76 : 0;
      case (ph % 4)
        0: begin w = $urandom_range(1024, 1); h = $urandom_range(1024, 1); end
        1: begin w = $urandom_range(8, 1); h = $urandom_range(8, 1); end
        2: begin w = 1024; h = $urandom_range(2047, 1025); end
        default: begin w = $urandom_range(2047); h = $urandom_range(1024); end
      endcase
      set_screen($urandom_range(24'hFFFFFF), $urandom_range(24'hFFFFFF),
                 $urandom_range(24'hFFFFFF), $urandom_range(24'hFFFFFF), w, h);
      random_pixels(100);
      drain();
    end

    $display("covered %0d pixels over %0d register settings, %0d off-screen",
             colors_seen, configs_run, oor_seen);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end
endmodule
